// ===== hdl/ofd_pkg.sv =====
// Shared constants, codes and types of the overlap frame deinterleaver.
package ofd_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int FRAME_MAX    = 512;
    localparam int RING_LEN     = 2 * FRAME_MAX;
    localparam int RING_DEPTH   = MAX_CHANNELS * RING_LEN;

    localparam int CH_W   = $clog2(MAX_CHANNELS);
    localparam int POS_W  = $clog2(RING_LEN);
    localparam int ADDR_W = CH_W + POS_W;

    localparam int DATA_W = 32;
    localparam int PCM_W  = 16;
    localparam int CC_W   = 4;
    localparam int LEN_W  = 10;
    localparam int CFG_W  = 10;
    localparam int CIDX_W = 2;
    localparam int REQ_W  = 2;
    localparam int RCH_W  = 3;
    localparam int RIDX_W = 9;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 2'd0,
        REQ_FLUSH = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NOP   = 2'd3
    } t_req_type;

    typedef enum logic [CIDX_W-1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_FRAME_LEN     = 2'd1,
        CFG_HOP_LEN       = 2'd2,
        CFG_SAMPLE_FORMAT = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } t_ring_req;

endpackage

// ===== hdl/ofd_ring_store.sv =====
// Per-channel sample ring memory with a zero-clearing sweep after reset.
module ofd_ring_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ofd_pkg::t_ring_req        i_req,
    output logic [ofd_pkg::DATA_W-1:0] o_rd_data,
    output logic                      o_clear_done
);
    import ofd_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RING_DEPTH - 1);

    logic [DATA_W-1:0] r_mem [RING_DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clr_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (!r_clr_done) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_clr_done) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_done && i_req.re) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data    = r_rd_data;
    assign o_clear_done = r_clr_done;

endmodule

// ===== hdl/overlap_frame_deinterleaver_core.sv =====
// Top level of the overlap frame deinterleaver: request control and result register.
//
//   channel   direction  handshake                  payload
//   in        into core  i_in_valid / o_in_stall    req_type, sample_word, read_channel,
//                                                   read_index
//   out       from core  o_out_valid / i_out_stall  read_data, frame_ready, frame_padded
//   cfg       into core  i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
// A push, a no-op or an out-of-range read loads the result register directly; an in-range
// read first passes the registered read port of the ring memory and then the S_READ state.
// A flush writes one zero to every ring entry still open in the hop in S_FLUSH, up to
// MAX_CHANNELS * hop_len writes through the single memory write port, and then loads the result.
// After reset the ring memory is cleared, all RING_DEPTH (8192) entries, before the first
// transfer is accepted; configuration writes are taken during that time.
// A stalled result holds its register, and no new request is accepted until it can load.
module overlap_frame_deinterleaver_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ofd_pkg::REQ_W-1:0]   i_req_type,
    input  logic [ofd_pkg::DATA_W-1:0]  i_sample_word,
    input  logic [ofd_pkg::RCH_W-1:0]   i_read_channel,
    input  logic [ofd_pkg::RIDX_W-1:0]  i_read_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ofd_pkg::DATA_W-1:0]  o_read_data,
    output logic                        o_frame_ready,
    output logic                        o_frame_padded,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ofd_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [ofd_pkg::CFG_W-1:0]   i_cfg_data
);
    import ofd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FLUSH
    } t_state;

    localparam logic [CC_W-1:0]  CC_MAX    = CC_W'(MAX_CHANNELS);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(FRAME_MAX);
    localparam logic [CH_W-1:0]  CH_LAST   = CH_W'(MAX_CHANNELS - 1);
    localparam int               SUM_W     = LEN_W + 2;

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_base, n_base;
    logic [LEN_W-1:0]   r_fill, n_fill;
    logic [CH_W-1:0]    r_gc, n_gc;
    logic [LEN_W-1:0]   r_fl_s, n_fl_s;
    logic [CH_W-1:0]    r_fl_c, n_fl_c;
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_read_data, n_read_data;
    logic               r_frame_ready, n_frame_ready;
    logic               r_frame_padded, n_frame_padded;

    logic [CC_W-1:0]    r_channel_count;
    logic [LEN_W-1:0]   r_frame_len;
    logic [LEN_W-1:0]   r_hop_len;
    logic               r_sample_format;

    logic [CC_W-1:0]    nch;
    logic [LEN_W-1:0]   flen;
    logic [LEN_W-1:0]   hop;
    logic               out_free;
    logic               in_accept;
    logic               clear_done;
    logic [DATA_W-1:0]  rd_data;
    t_ring_req          ring_req;

    logic [DATA_W-1:0]  push_value;
    logic [CH_W-1:0]    push_ch;
    logic [CC_W-1:0]    push_ch_next;
    logic [LEN_W-1:0]   push_fill_next;
    logic [SUM_W-1:0]   push_sum;
    logic [SUM_W-1:0]   flush_sum;
    logic [SUM_W-1:0]   read_sum;
    logic [SUM_W-1:0]   commit_sum;
    logic               read_in_range;

    always_comb begin
        if (r_channel_count == '0) begin
            nch = CC_W'(1);
        end else if (r_channel_count > CC_MAX) begin
            nch = CC_MAX;
        end else begin
            nch = r_channel_count;
        end
        if (r_frame_len == '0) begin
            flen = LEN_W'(1);
        end else if (r_frame_len > LEN_MAX) begin
            flen = LEN_MAX;
        end else begin
            flen = r_frame_len;
        end
        if (r_hop_len == '0) begin
            hop = LEN_W'(1);
        end else if (r_hop_len > flen) begin
            hop = flen;
        end else begin
            hop = r_hop_len;
        end
    end

    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && clear_done && out_free);
    assign in_accept = i_in_valid && !o_in_stall;

    assign push_value = r_sample_format ? i_sample_word
                      : {{(DATA_W - PCM_W){i_sample_word[PCM_W-1]}}, i_sample_word[PCM_W-1:0]};
    assign push_ch    = ({1'b0, r_gc} >= nch) ? '0 : r_gc;
    assign push_ch_next   = {1'b0, push_ch} + 1'b1;
    assign push_fill_next = r_fill + 1'b1;
    assign push_sum   = SUM_W'(r_base) + SUM_W'(flen) + SUM_W'(r_fill);
    assign flush_sum  = SUM_W'(r_base) + SUM_W'(flen) + SUM_W'(r_fl_s);
    assign read_sum   = SUM_W'(r_base) + SUM_W'(i_read_index);
    assign commit_sum = SUM_W'(r_base) + SUM_W'(hop);
    assign read_in_range = ({1'b0, i_read_channel} < nch)
                        && (LEN_W'(i_read_index) < flen);

    always_comb begin
        n_state        = r_state;
        n_base         = r_base;
        n_fill         = r_fill;
        n_gc           = r_gc;
        n_fl_s         = r_fl_s;
        n_fl_c         = r_fl_c;
        n_out_valid    = r_out_valid && i_out_stall;
        n_read_data    = r_read_data;
        n_frame_ready  = r_frame_ready;
        n_frame_padded = r_frame_padded;
        ring_req       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    unique case (t_req_type'(i_req_type))
                        REQ_PUSH: begin
                            ring_req.we    = 1'b1;
                            ring_req.addr  = {push_ch, push_sum[POS_W-1:0]};
                            ring_req.wdata = push_value;
                            n_out_valid    = 1'b1;
                            n_read_data    = '0;
                            n_frame_ready  = 1'b0;
                            n_frame_padded = 1'b0;
                            if (push_ch_next >= nch) begin
                                n_gc = '0;
                                if (push_fill_next >= hop) begin
                                    n_fill        = '0;
                                    n_base        = commit_sum[POS_W-1:0];
                                    n_frame_ready = 1'b1;
                                end else begin
                                    n_fill = push_fill_next;
                                end
                            end else begin
                                n_gc = push_ch_next[CH_W-1:0];
                            end
                        end
                        REQ_FLUSH: begin
                            n_fl_s  = r_fill;
                            n_fl_c  = r_gc;
                            n_state = S_FLUSH;
                        end
                        REQ_READ: begin
                            if (read_in_range) begin
                                ring_req.re   = 1'b1;
                                ring_req.addr = {i_read_channel[CH_W-1:0],
                                                 read_sum[POS_W-1:0]};
                                n_state       = S_READ;
                            end else begin
                                n_out_valid    = 1'b1;
                                n_read_data    = '0;
                                n_frame_ready  = 1'b0;
                                n_frame_padded = 1'b0;
                            end
                        end
                        REQ_NOP: begin
                            n_out_valid    = 1'b1;
                            n_read_data    = '0;
                            n_frame_ready  = 1'b0;
                            n_frame_padded = 1'b0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_read_data    = rd_data;
                    n_frame_ready  = 1'b0;
                    n_frame_padded = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (r_fl_s >= hop) begin
                    if (out_free) begin
                        n_out_valid    = 1'b1;
                        n_read_data    = '0;
                        n_frame_ready  = 1'b1;
                        n_frame_padded = 1'b1;
                        n_fill         = '0;
                        n_gc           = '0;
                        n_base         = commit_sum[POS_W-1:0];
                        n_state        = S_IDLE;
                    end
                end else begin
                    ring_req.we    = 1'b1;
                    ring_req.addr  = {r_fl_c, flush_sum[POS_W-1:0]};
                    ring_req.wdata = '0;
                    if (r_fl_c == CH_LAST) begin
                        n_fl_c = '0;
                        n_fl_s = r_fl_s + 1'b1;
                    end else begin
                        n_fl_c = r_fl_c + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_fill      <= '0;
            r_gc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_fill      <= n_fill;
            r_gc        <= n_gc;
            r_out_valid <= n_out_valid;
        end
        r_fl_s         <= n_fl_s;
        r_fl_c         <= n_fl_c;
        r_read_data    <= n_read_data;
        r_frame_ready  <= n_frame_ready;
        r_frame_padded <= n_frame_padded;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CC_W'(1);
            r_frame_len     <= LEN_W'(512);
            r_hop_len       <= LEN_W'(512);
            r_sample_format <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CC_W-1:0];
                CFG_FRAME_LEN:     r_frame_len     <= i_cfg_data[LEN_W-1:0];
                CFG_HOP_LEN:       r_hop_len       <= i_cfg_data[LEN_W-1:0];
                CFG_SAMPLE_FORMAT: r_sample_format <= i_cfg_data[0];
                default:           r_sample_format <= r_sample_format;
            endcase
        end
    end

    ofd_ring_store u_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (ring_req),
        .o_rd_data    (rd_data),
        .o_clear_done (clear_done)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_read_data;
    assign o_frame_ready  = r_frame_ready;
    assign o_frame_padded = r_frame_padded;

endmodule

// ===== hdl/ofd_checker.sv =====
// Port-level assertions for the overlap frame deinterleaver and their binding.
module ofd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic [ofd_pkg::REQ_W-1:0]   i_req_type,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [ofd_pkg::DATA_W-1:0]  o_read_data,
    input logic                        o_frame_ready,
    input logic                        o_frame_padded
);
    import ofd_pkg::*;

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data)
            && $stable(o_frame_ready) && $stable(o_frame_padded))
        else $error("stalled result changed");

    a_padded_is_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_padded |-> o_frame_ready)
        else $error("padded result without a committed frame");

    a_frame_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_ready |-> o_read_data == '0)
        else $error("frame commit carries read data");

    a_flush_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_req_type == REQ_FLUSH) |=> o_in_stall)
        else $error("transfer accepted right after a flush");

endmodule

bind overlap_frame_deinterleaver_core ofd_checker u_ofd_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the overlap frame deinterleaver core with a bit-exact frame predictor.
module tb_top;
    import ofd_pkg::*;

    localparam int  RANDOM_ITEMS   = 1500;
    localparam int  RX_HOLD_CYCLES = 400;
    localparam longint RUN_LIMIT   = 64'd30_000_000;

    typedef struct packed {
        t_req_type         req;
        logic [DATA_W-1:0] word;
        logic [RCH_W-1:0]  rch;
        logic [RIDX_W-1:0] ridx;
    } t_frame_req;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              ready;
        logic              padded;
    } t_frame_result;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_stall;
    logic [REQ_W-1:0]    i_req_type     = '0;
    logic [DATA_W-1:0]   i_sample_word  = '0;
    logic [RCH_W-1:0]    i_read_channel = '0;
    logic [RIDX_W-1:0]   i_read_index   = '0;
    logic                o_out_valid;
    logic                i_out_stall    = 1'b0;
    logic [DATA_W-1:0]   o_read_data;
    logic                o_frame_ready;
    logic                o_frame_padded;
    logic                i_cfg_valid    = 1'b0;
    logic                o_cfg_ready;
    logic [CIDX_W-1:0]   i_cfg_index    = '0;
    logic [CFG_W-1:0]    i_cfg_data     = '0;

    t_frame_req    req_fifo[$];
    t_frame_result frame_results[$];
    t_frame_req    cur_req;
    t_frame_result front_result;

    logic [DATA_W-1:0] ring_model [RING_DEPTH];
    int unsigned       base_pos;
    int unsigned       hop_cnt;
    int unsigned       grp_ch;
    logic [CC_W-1:0]   cfg_chans;
    logic [LEN_W-1:0]  cfg_frame;
    logic [LEN_W-1:0]  cfg_hop;
    logic              cfg_fmt;

    bit          idling      = 1'b1;
    bit          rx_hold     = 1'b0;
    bit          rx_hold_go  = 1'b0;
    int unsigned tx_gap      = 0;
    int unsigned rx_gap      = 0;
    int          fail_count  = 0;

    overlap_frame_deinterleaver_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_sample_word  (i_sample_word),
        .i_read_channel (i_read_channel),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data),
        .o_frame_ready  (o_frame_ready),
        .o_frame_padded (o_frame_padded),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned clamped_channels();
        if (cfg_chans < 1) return 1;
        if (cfg_chans > MAX_CHANNELS) return MAX_CHANNELS;
        return 32'(cfg_chans);
    endfunction

    function automatic int unsigned clamped_frame();
        if (cfg_frame < 1) return 1;
        if (cfg_frame > FRAME_MAX) return FRAME_MAX;
        return 32'(cfg_frame);
    endfunction

    function automatic int unsigned clamped_hop(int unsigned f);
        if (cfg_hop < 1) return 1;
        if (cfg_hop > f) return f;
        return 32'(cfg_hop);
    endfunction

    function automatic int unsigned ring_index(int unsigned ch, int unsigned pos);
        return (ch % MAX_CHANNELS) * RING_LEN + (pos % RING_LEN);
    endfunction

    function automatic void advance_frame(int unsigned h);
        base_pos = (base_pos + h) % RING_LEN;
        hop_cnt  = 0;
        grp_ch   = 0;
    endfunction

    function automatic t_frame_result step_deinterleaver(t_frame_req rq);
        t_frame_result     res;
        int unsigned       nch;
        int unsigned       f;
        int unsigned       h;
        int unsigned       s;
        int unsigned       c;
        logic [DATA_W-1:0] v;
        nch = clamped_channels();
        f   = clamped_frame();
        h   = clamped_hop(f);
        res = '0;
        case (rq.req)
            REQ_PUSH: begin
                v = cfg_fmt ? rq.word
                            : {{(DATA_W-PCM_W){rq.word[PCM_W-1]}}, rq.word[PCM_W-1:0]};
                if (grp_ch >= nch) grp_ch = 0;
                ring_model[ring_index(grp_ch, base_pos + f + hop_cnt)] = v;
                grp_ch++;
                if (grp_ch >= nch) begin
                    grp_ch  = 0;
                    hop_cnt = (hop_cnt + 1) & 32'h3FF;
                    if (hop_cnt >= h) begin
                        advance_frame(h);
                        res.ready = 1'b1;
                    end
                end
            end
            REQ_FLUSH: begin
                for (s = hop_cnt; s < h; s++) begin
                    for (c = (s == hop_cnt) ? grp_ch : 0; c < MAX_CHANNELS; c++) begin
                        ring_model[ring_index(c, base_pos + f + s)] = '0;
                    end
                end
                advance_frame(h);
                res.ready  = 1'b1;
                res.padded = 1'b1;
            end
            REQ_READ: begin
                if (rq.rch < nch && rq.ridx < f) begin
                    res.data = ring_model[ring_index(rq.rch, base_pos + rq.ridx)];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Request driver: one transfer per accepted item, a random gap after each while idling is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                frame_results.push_back(step_deinterleaver(cur_req));
                tx_gap = idling ? $urandom_range(0, 7) : 0;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (req_fifo.size() > 0) begin
                    cur_req = req_fifo.pop_front();
                    i_req_type     <= cur_req.req;
                    i_sample_word  <= cur_req.word;
                    i_read_channel <= cur_req.rch;
                    i_read_index   <= cur_req.ridx;
                    i_in_valid     <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (frame_results.size() == 0) begin
                    $error("result transfer with no outstanding request");
                    fail_count++;
                end else begin
                    front_result = frame_results.pop_front();
                    if (o_read_data !== front_result.data) begin
                        $error("read_data: expected %h, got %h", front_result.data, o_read_data);
                        fail_count++;
                    end
                    if (o_frame_ready !== front_result.ready) begin
                        $error("frame_ready: expected %b, got %b", front_result.ready,
                               o_frame_ready);
                        fail_count++;
                    end
                    if (o_frame_padded !== front_result.padded) begin
                        $error("frame_padded: expected %b, got %b", front_result.padded,
                               o_frame_padded);
                        fail_count++;
                    end
                end
                rx_gap = idling ? $urandom_range(0, 7) : 0;
            end else if (rx_gap > 0) begin
                rx_gap--;
            end
            i_out_stall <= rx_hold || (rx_gap > 0);
        end
    end

    initial begin
        wait (rx_hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    task automatic write_reg(t_cfg_index idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CHANNEL_COUNT: cfg_chans = data[CC_W-1:0];
            CFG_FRAME_LEN:     cfg_frame = data[LEN_W-1:0];
            CFG_HOP_LEN:       cfg_hop   = data[LEN_W-1:0];
            CFG_SAMPLE_FORMAT: cfg_fmt   = data[0];
            default: begin
            end
        endcase
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (req_fifo.size() > 0 || i_in_valid || frame_results.size() > 0);
    endtask

    task automatic add_req(t_req_type rt, logic [DATA_W-1:0] w, logic [RCH_W-1:0] ch,
                           logic [RIDX_W-1:0] ix);
        req_fifo.push_back('{rt, w, ch, ix});
    endtask

    task automatic add_noisy(t_req_type rt);
        add_req(rt, $urandom(), RCH_W'($urandom_range(0, 7)),
                RIDX_W'($urandom_range(0, 511)));
    endtask

    task automatic pick_settings();
        int unsigned r;
        logic [CFG_W-1:0] fl;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            write_reg(CFG_CHANNEL_COUNT, CFG_W'($urandom_range(0, 1023)));
        end else if (r < 85) begin
            write_reg(CFG_CHANNEL_COUNT, {6'($urandom_range(0, 63)), 4'($urandom_range(1, 8))});
        end
        r = $urandom_range(0, 99);
        if (r < 5) fl = CFG_W'(FRAME_MAX);
        else if (r < 10) fl = CFG_W'($urandom_range(0, 1023));
        else if (r < 25) fl = CFG_W'($urandom_range(17, 64));
        else fl = CFG_W'($urandom_range(1, 16));
        if ($urandom_range(0, 99) < 85) write_reg(CFG_FRAME_LEN, fl);
        r = $urandom_range(0, 99);
        if (r < 15) begin
            write_reg(CFG_HOP_LEN, CFG_W'($urandom_range(0, 1023)));
        end else if (r < 85) begin
            write_reg(CFG_HOP_LEN, CFG_W'($urandom_range(1, clamped_frame())));
        end
        if ($urandom_range(0, 99) < 85) begin
            write_reg(CFG_SAMPLE_FORMAT, CFG_W'($urandom_range(0, 1023)));
        end
    endtask

    task automatic queue_random_batch(int n, output int made);
        int unsigned nch;
        int unsigned f;
        int unsigned r;
        int unsigned k;
        int unsigned lim;
        made = 0;
        nch  = clamped_channels();
        f    = clamped_frame();
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                for (k = 0; k < nch; k++) add_noisy(REQ_PUSH);
                made += nch;
            end else if (r < 85) begin
                add_req(REQ_READ, $urandom(),
                        ($urandom_range(0, 99) < 85) ? RCH_W'($urandom_range(0, nch - 1))
                                                     : RCH_W'($urandom_range(0, 7)),
                        ($urandom_range(0, 99) < 85) ? RIDX_W'($urandom_range(0, f - 1))
                                                     : RIDX_W'($urandom_range(0, 511)));
                made++;
            end else if (r < 91) begin
                add_noisy(REQ_FLUSH);
                made++;
            end else if (r < 95) begin
                add_noisy(REQ_NOP);
                made++;
            end else begin
                lim = $urandom_range(1, nch);
                for (k = 0; k < lim; k++) add_noisy(REQ_PUSH);
                made += lim;
            end
        end
    endtask

    initial begin
        int made;
        int total;
        int phase;
        for (int i = 0; i < RING_DEPTH; i++) ring_model[i] = '0;
        base_pos  = 0;
        hop_cnt   = 0;
        grp_ch    = 0;
        cfg_chans = 4'd1;
        cfg_frame = 10'd512;
        cfg_hop   = 10'd512;
        cfg_fmt   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_reg(CFG_CHANNEL_COUNT, 10'h002);
        write_reg(CFG_FRAME_LEN, 10'h004);
        write_reg(CFG_HOP_LEN, 10'h002);
        write_reg(CFG_SAMPLE_FORMAT, 10'h3FE);
        add_req(REQ_PUSH, 32'h1234_8000, 3'd0, 9'd0);
        add_req(REQ_PUSH, 32'hFFFF_7FFF, 3'd7, 9'd511);
        add_req(REQ_PUSH, 32'h0000_FFFF, 3'd0, 9'd0);
        add_req(REQ_PUSH, 32'hFFFF_FFFF, 3'd7, 9'd511);
        add_req(REQ_READ, 32'h0, 3'd0, 9'd2);
        add_req(REQ_READ, 32'h0, 3'd1, 9'd3);
        add_req(REQ_READ, 32'hFFFF_FFFF, 3'd2, 9'd0);
        add_req(REQ_READ, 32'h0, 3'd1, 9'd4);
        add_req(REQ_READ, 32'h0, 3'd7, 9'd511);
        add_req(REQ_PUSH, 32'h0000_0001, 3'd0, 9'd0);
        add_noisy(REQ_FLUSH);
        add_noisy(REQ_FLUSH);
        add_noisy(REQ_NOP);
        wait_idle();

        // Channel count and frame length above range, hop length zero, float samples.
        write_reg(CFG_SAMPLE_FORMAT, 10'h001);
        write_reg(CFG_CHANNEL_COUNT, 10'h00F);
        write_reg(CFG_FRAME_LEN, 10'h3FF);
        write_reg(CFG_HOP_LEN, 10'h000);
        add_req(REQ_PUSH, 32'h8000_0000, 3'd0, 9'd0);
        add_req(REQ_PUSH, 32'h7FFF_FFFF, 3'd0, 9'd0);
        add_req(REQ_PUSH, 32'hFFFF_FFFF, 3'd0, 9'd0);
        add_req(REQ_PUSH, 32'h0000_0000, 3'd0, 9'd0);
        repeat (4) add_noisy(REQ_PUSH);
        add_req(REQ_READ, 32'h0, 3'd7, 9'd511);
        add_req(REQ_READ, 32'h0, 3'd0, 9'd511);
        repeat (3) add_noisy(REQ_PUSH);
        wait_idle();

        // The open group lies beyond the new channel count; the flush walks the rest of a hop as long as the frame.
        write_reg(CFG_CHANNEL_COUNT, 10'h3F2);
        write_reg(CFG_HOP_LEN, 10'h3FF);
        repeat (2) add_noisy(REQ_PUSH);
        add_noisy(REQ_FLUSH);
        add_req(REQ_READ, 32'h0, 3'd1, 9'd511);
        add_req(REQ_READ, 32'h0, 3'd0, 9'd510);
        wait_idle();

        // The collected hop already exceeds the new hop length.
        write_reg(CFG_CHANNEL_COUNT, 10'h000);
        write_reg(CFG_FRAME_LEN, 10'h008);
        write_reg(CFG_HOP_LEN, 10'h004);
        write_reg(CFG_SAMPLE_FORMAT, 10'h000);
        repeat (3) add_noisy(REQ_PUSH);
        wait_idle();
        write_reg(CFG_HOP_LEN, 10'h002);
        add_noisy(REQ_PUSH);
        add_req(REQ_READ, 32'h0, 3'd0, 9'd7);
        wait_idle();

        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS) begin
            pick_settings();
            idling = ($urandom_range(0, 3) != 0);
            if (phase == 3) begin
                queue_random_batch(150, made);
                rx_hold_go = 1'b1;
            end else begin
                queue_random_batch($urandom_range(40, 120), made);
            end
            total += made;
            phase++;
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && frame_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ofd_pkg.sv
hdl/ofd_ring_store.sv
hdl/overlap_frame_deinterleaver_core.sv
hdl/ofd_checker.sv
sim/tb_top.sv
